### rtl/taf_pkg.sv
`default_nettype none

package taf_pkg;

    localparam int POINT_COUNT_DEF = 256;

    localparam int IDX_W      = 8;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 32;
    localparam int RAD_W      = 34;
    localparam int ROOT_W     = 31;
    localparam int REM_W      = 32;
    localparam int SQRT_STEPS = 31;
    localparam int FRAC_SHIFT = 28;
    localparam int NUM_W      = 45;
    localparam int DIV_STEPS  = 15;
    localparam int UNIT_W     = 16;
    localparam int PROD_W     = 32;
    localparam int CROSS_W    = 33;
    localparam int FEAT_W     = 17;
    localparam int CORNERS    = 3;

    // B, C, normalize-numerator and final stages around the sqrt and divide steps
    localparam int EDGE_LAT = SQRT_STEPS + DIV_STEPS + 4;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 56;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [DIV_STEPS-1:0]     UNIT_ONE    = DIV_STEPS'(16384);
    localparam logic signed [FEAT_W-1:0] FEAT_ONE    = FEAT_W'(4096);
    localparam logic signed [FEAT_W-1:0] DUP_FEATURE = -FEAT_W'(40960);
    localparam logic signed [CROSS_W-1:0] ROUND_HALF = CROSS_W'(32768);

    typedef enum logic {
        REQ_WRITE   = 1'b0,
        REQ_COMPUTE = 1'b1
    } t_req;

    typedef struct packed {
        t_req                              req;
        logic                              dup;
        logic [IDX_W-1:0]                  point_index;
        logic signed [COORD_W-1:0]         coord_x;
        logic signed [COORD_W-1:0]         coord_y;
        logic [CORNERS-1:0][IDX_W-1:0]     corner;
    } t_job;

endpackage

`default_nettype wire

### rtl/triangle_angle_feature.sv
`default_nettype none

// Triangle angle sine features over a table of POINT_COUNT 2-D points (signed Q11.4).
// Input beats with tuser 0 write one point; beats with tuser 1 name three corners and
// give one output beat with the three cross products of consecutive unit edges in
// Q4.12, or -10 for all three with tuser set when two corners are equal. Writes give
// no output beat. Beats pass through a four-entry job queue into a fully pipelined
// kernel that takes one beat per cycle while the output is not held by back-pressure;
// each edge unit has 31 square root steps and 15 divide steps. The point table is
// held in three copies, one read port per corner, and writes and triangle requests
// keep their order through the queue. Unwritten table entries read as unknown.
module triangle_angle_feature #(
    parameter int POINT_COUNT = taf_pkg::POINT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // point_index, coord_x, coord_y, first_index, second_index, third_index
    input  logic [taf_pkg::S_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // feature_first, feature_second, feature_third, zero fill
    output logic [taf_pkg::M_DATA_W-1:0]  o_m_tdata,
    // duplicate_indices
    output logic [0:0]                    o_m_tuser
);
    import taf_pkg::*;

    t_job w_in_job;
    t_job w_q_job;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    taf_front u_front (
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_user  (i_s_tuser),
        .i_full  (w_full),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_job   (w_in_job)
    );

    taf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_q_job),
        .o_empty (w_empty)
    );

    taf_back #(
        .POINT_COUNT (POINT_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_q_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser)
    );

endmodule

`default_nettype wire

### rtl/taf_front.sv
`default_nettype none

module taf_front (
    input  logic                          i_valid,
    // point_index, coord_x, coord_y, first_index, second_index, third_index
    input  logic [taf_pkg::S_DATA_W-1:0]  i_data,
    // req_type
    input  logic [0:0]                    i_user,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output taf_pkg::t_job                 o_job
);
    import taf_pkg::*;

    logic [IDX_W-1:0] w_a;
    logic [IDX_W-1:0] w_b;
    logic [IDX_W-1:0] w_c;

    assign w_a = i_data[47:40];
    assign w_b = i_data[55:48];
    assign w_c = i_data[63:56];

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_job.req         = t_req'(i_user[0]);
        o_job.dup         = (w_a == w_b) || (w_a == w_c) || (w_b == w_c);
        o_job.point_index = i_data[7:0];
        o_job.coord_x     = i_data[23:8];
        o_job.coord_y     = i_data[39:24];
        o_job.corner[0]   = w_a;
        o_job.corner[1]   = w_b;
        o_job.corner[2]   = w_c;
    end

endmodule

`default_nettype wire

### rtl/taf_fifo.sv
`default_nettype none

module taf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  taf_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output taf_pkg::t_job  o_job,
    output logic           o_empty
);
    import taf_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + FIFO_CW'(1)))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

### rtl/taf_edge_unit.sv
`default_nettype none

module taf_edge_unit (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [taf_pkg::DIFF_W-1:0]  i_dx,
    input  logic signed [taf_pkg::DIFF_W-1:0]  i_dy,
    output logic signed [taf_pkg::UNIT_W-1:0]  o_ux,
    output logic signed [taf_pkg::UNIT_W-1:0]  o_uy
);
    import taf_pkg::*;

    logic signed [2*DIFF_W-1:0] w_px;
    logic signed [2*DIFF_W-1:0] w_py;
    logic [DIFF_W-1:0]          w_negx;
    logic [DIFF_W-1:0]          w_negy;

    logic [SQ_W-1:0]  r_sqx;
    logic [SQ_W-1:0]  r_sqy;
    logic [MAG_W-1:0] r_bmagx;
    logic [MAG_W-1:0] r_bmagy;
    logic             r_bsgnx;
    logic             r_bsgny;

    logic [RAD_W-1:0]  r_rad   [SQRT_STEPS+1];
    logic [ROOT_W-1:0] r_root  [SQRT_STEPS+1];
    logic [REM_W-1:0]  r_rem   [SQRT_STEPS+1];
    logic [MAG_W-1:0]  r_smagx [SQRT_STEPS+1];
    logic [MAG_W-1:0]  r_smagy [SQRT_STEPS+1];
    logic              r_ssgnx [SQRT_STEPS+1];
    logic              r_ssgny [SQRT_STEPS+1];
    logic              r_szero [SQRT_STEPS+1];

    logic [RAD_W-1:0] w_cur   [SQRT_STEPS];
    logic [RAD_W-1:0] w_trial [SQRT_STEPS];
    logic [RAD_W-1:0] w_diff  [SQRT_STEPS];
    logic             w_take  [SQRT_STEPS];

    logic [NUM_W-1:0]     r_dremx [DIV_STEPS+1];
    logic [NUM_W-1:0]     r_dremy [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_dqx   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_dqy   [DIV_STEPS+1];
    logic [ROOT_W-1:0]    r_ds    [DIV_STEPS+1];
    logic                 r_dsgnx [DIV_STEPS+1];
    logic                 r_dsgny [DIV_STEPS+1];
    logic                 r_dzero [DIV_STEPS+1];

    logic [NUM_W-1:0] w_dvs   [DIV_STEPS];
    logic             w_takex [DIV_STEPS];
    logic             w_takey [DIV_STEPS];

    logic [DIV_STEPS-1:0]      w_qcx;
    logic [DIV_STEPS-1:0]      w_qcy;
    logic signed [UNIT_W-1:0]  n_ux;
    logic signed [UNIT_W-1:0]  n_uy;

    assign w_px   = i_dx * i_dx;
    assign w_py   = i_dy * i_dy;
    assign w_negx = -i_dx;
    assign w_negy = -i_dy;

    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            w_cur[k]   = {r_rem[k], r_rad[k][RAD_W-1 -: 2]};
            w_trial[k] = {1'b0, r_root[k], 2'b01};
            w_take[k]  = (w_cur[k] >= w_trial[k]);
            w_diff[k]  = w_cur[k] - w_trial[k];
        end
        for (int t = 0; t < DIV_STEPS; t++) begin
            w_dvs[t]   = NUM_W'(r_ds[t]) << (DIV_STEPS - 1 - t);
            w_takex[t] = (r_dremx[t] >= w_dvs[t]);
            w_takey[t] = (r_dremy[t] >= w_dvs[t]);
        end
    end

    always_comb begin
        w_qcx = (r_dqx[DIV_STEPS] > UNIT_ONE) ? UNIT_ONE : r_dqx[DIV_STEPS];
        w_qcy = (r_dqy[DIV_STEPS] > UNIT_ONE) ? UNIT_ONE : r_dqy[DIV_STEPS];
        if (r_dzero[DIV_STEPS]) begin
            n_ux = '0;
            n_uy = '0;
        end else begin
            n_ux = r_dsgnx[DIV_STEPS] ? -$signed({1'b0, w_qcx}) : $signed({1'b0, w_qcx});
            n_uy = r_dsgny[DIV_STEPS] ? -$signed({1'b0, w_qcy}) : $signed({1'b0, w_qcy});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // squares and magnitudes
            r_sqx   <= w_px[SQ_W-1:0];
            r_sqy   <= w_py[SQ_W-1:0];
            r_bmagx <= i_dx[DIFF_W-1] ? w_negx[MAG_W-1:0] : i_dx[MAG_W-1:0];
            r_bmagy <= i_dy[DIFF_W-1] ? w_negy[MAG_W-1:0] : i_dy[MAG_W-1:0];
            r_bsgnx <= i_dx[DIFF_W-1];
            r_bsgny <= i_dy[DIFF_W-1];

            // squared length, root seed
            r_rad[0]   <= {1'b0, {1'b0, r_sqx} + {1'b0, r_sqy}};
            r_root[0]  <= '0;
            r_rem[0]   <= '0;
            r_smagx[0] <= r_bmagx;
            r_smagy[0] <= r_bmagy;
            r_ssgnx[0] <= r_bsgnx;
            r_ssgny[0] <= r_bsgny;
            r_szero[0] <= (r_sqx == '0) && (r_sqy == '0);

            // one root bit per stage
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_rad[k+1]   <= {r_rad[k][RAD_W-3:0], 2'b00};
                r_root[k+1]  <= {r_root[k][ROOT_W-2:0], w_take[k]};
                r_rem[k+1]   <= w_take[k] ? w_diff[k][REM_W-1:0] : w_cur[k][REM_W-1:0];
                r_smagx[k+1] <= r_smagx[k];
                r_smagy[k+1] <= r_smagy[k];
                r_ssgnx[k+1] <= r_ssgnx[k];
                r_ssgny[k+1] <= r_ssgny[k];
                r_szero[k+1] <= r_szero[k];
            end

            // rounded numerators
            r_dremx[0] <= NUM_W'({r_smagx[SQRT_STEPS], {FRAC_SHIFT{1'b0}}})
                        + NUM_W'(r_root[SQRT_STEPS] >> 1);
            r_dremy[0] <= NUM_W'({r_smagy[SQRT_STEPS], {FRAC_SHIFT{1'b0}}})
                        + NUM_W'(r_root[SQRT_STEPS] >> 1);
            r_dqx[0]   <= '0;
            r_dqy[0]   <= '0;
            r_ds[0]    <= r_root[SQRT_STEPS];
            r_dsgnx[0] <= r_ssgnx[SQRT_STEPS];
            r_dsgny[0] <= r_ssgny[SQRT_STEPS];
            r_dzero[0] <= r_szero[SQRT_STEPS];

            // one quotient bit per stage
            for (int t = 0; t < DIV_STEPS; t++) begin
                r_dremx[t+1] <= w_takex[t] ? r_dremx[t] - w_dvs[t] : r_dremx[t];
                r_dremy[t+1] <= w_takey[t] ? r_dremy[t] - w_dvs[t] : r_dremy[t];
                r_dqx[t+1]   <= {r_dqx[t][DIV_STEPS-2:0], w_takex[t]};
                r_dqy[t+1]   <= {r_dqy[t][DIV_STEPS-2:0], w_takey[t]};
                r_ds[t+1]    <= r_ds[t];
                r_dsgnx[t+1] <= r_dsgnx[t];
                r_dsgny[t+1] <= r_dsgny[t];
                r_dzero[t+1] <= r_dzero[t];
            end

            o_ux <= n_ux;
            o_uy <= n_uy;
        end
    end

endmodule

`default_nettype wire

### rtl/taf_back.sv
`default_nettype none

module taf_back #(
    parameter int POINT_COUNT = taf_pkg::POINT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  taf_pkg::t_job                 i_job,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    // feature_first, feature_second, feature_third, zero fill
    output logic [taf_pkg::M_DATA_W-1:0]  o_data,
    // duplicate_indices
    output logic [0:0]                    o_user
);
    import taf_pkg::*;

    localparam int AW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;

    logic                      w_en;
    logic                      w_wr_inr;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [AW-1:0]             w_raddr [CORNERS];
    logic                      w_rinr  [CORNERS];

    logic [2*COORD_W-1:0]      r_mem [CORNERS][POINT_COUNT];

    logic                      r_v0;
    logic                      r_dup0;
    logic                      r_inr0 [CORNERS];
    logic [2*COORD_W-1:0]      r_rd   [CORNERS];

    logic signed [COORD_W-1:0] w_ptx [CORNERS];
    logic signed [COORD_W-1:0] w_pty [CORNERS];

    logic                      r_v1;
    logic                      r_dup1;
    logic signed [DIFF_W-1:0]  r_dx [CORNERS];
    logic signed [DIFF_W-1:0]  r_dy [CORNERS];

    logic signed [UNIT_W-1:0]  w_ux [CORNERS];
    logic signed [UNIT_W-1:0]  w_uy [CORNERS];

    logic                      r_vs [EDGE_LAT];
    logic                      r_ds [EDGE_LAT];

    logic                      r_v2;
    logic                      r_dup2;
    logic signed [PROD_W-1:0]  r_pa [CORNERS];
    logic signed [PROD_W-1:0]  r_pb [CORNERS];

    logic signed [CROSS_W-1:0] w_c [CORNERS];
    logic signed [FEAT_W-1:0]  w_r [CORNERS];
    logic signed [FEAT_W-1:0]  n_feat [CORNERS];

    logic                      r_out_valid;
    logic                      r_out_dup;
    logic signed [FEAT_W-1:0]  r_feat [CORNERS];

    assign w_en    = !r_out_valid || i_ready;
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_out_valid;
    assign o_user  = r_out_dup;
    assign o_data  = {{(M_DATA_W - CORNERS*FEAT_W){1'b0}}, r_feat[2], r_feat[1], r_feat[0]};

    assign w_waddr  = AW'(i_job.point_index);
    assign w_wr_inr = (32'(i_job.point_index) < 32'(POINT_COUNT));
    assign w_we     = o_pop && (i_job.req == REQ_WRITE) && w_wr_inr;

    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            w_raddr[c] = AW'(i_job.corner[c]);
            w_rinr[c]  = (32'(i_job.corner[c]) < 32'(POINT_COUNT));
            w_ptx[c]   = r_inr0[c] ? $signed(r_rd[c][COORD_W-1:0]) : '0;
            w_pty[c]   = r_inr0[c] ? $signed(r_rd[c][2*COORD_W-1:COORD_W]) : '0;
        end
    end

    // table copies, one per corner read
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CORNERS; c++) begin
            if (w_we) begin
                r_mem[c][w_waddr] <= {i_job.coord_y, i_job.coord_x};
            end
            if (w_en) begin
                r_rd[c] <= r_mem[c][w_raddr[c]];
            end
        end
    end

    for (genvar e = 0; e < CORNERS; e++) begin : g_edge
        taf_edge_unit u_edge (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_dx  (r_dx[e]),
            .i_dy  (r_dy[e]),
            .o_ux  (w_ux[e]),
            .o_uy  (w_uy[e])
        );
    end

    always_comb begin
        for (int e = 0; e < CORNERS; e++) begin
            w_c[e] = {r_pa[e][PROD_W-1], r_pa[e]} - {r_pb[e][PROD_W-1], r_pb[e]} + ROUND_HALF;
            w_r[e] = w_c[e][CROSS_W-1:CROSS_W-FEAT_W];
            if (r_dup2) begin
                n_feat[e] = DUP_FEATURE;
            end else if (w_r[e] > FEAT_ONE) begin
                n_feat[e] = FEAT_ONE;
            end else if (w_r[e] < -FEAT_ONE) begin
                n_feat[e] = -FEAT_ONE;
            end else begin
                n_feat[e] = w_r[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dup0 <= i_job.dup;
            for (int c = 0; c < CORNERS; c++) begin
                r_inr0[c] <= w_rinr[c];
            end
            r_dup1 <= r_dup0;
            for (int e = 0; e < CORNERS; e++) begin
                r_dx[e] <= {w_ptx[(e+1)%CORNERS][COORD_W-1], w_ptx[(e+1)%CORNERS]}
                         - {w_ptx[e][COORD_W-1], w_ptx[e]};
                r_dy[e] <= {w_pty[(e+1)%CORNERS][COORD_W-1], w_pty[(e+1)%CORNERS]}
                         - {w_pty[e][COORD_W-1], w_pty[e]};
            end
            r_ds[0] <= r_dup1;
            for (int i = 1; i < EDGE_LAT; i++) begin
                r_ds[i] <= r_ds[i-1];
            end
            r_dup2 <= r_ds[EDGE_LAT-1];
            for (int e = 0; e < CORNERS; e++) begin
                r_pa[e] <= w_ux[(e+1)%CORNERS] * w_uy[e];
                r_pb[e] <= w_uy[(e+1)%CORNERS] * w_ux[e];
            end
            r_out_dup <= r_dup2;
            for (int e = 0; e < CORNERS; e++) begin
                r_feat[e] <= n_feat[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < EDGE_LAT; i++) begin
                r_vs[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_v0    <= o_pop && (i_job.req == REQ_COMPUTE);
            r_v1    <= r_v0;
            r_vs[0] <= r_v1;
            for (int i = 1; i < EDGE_LAT; i++) begin
                r_vs[i] <= r_vs[i-1];
            end
            r_v2        <= r_vs[EDGE_LAT-1];
            r_out_valid <= r_v2;
        end
    end

    a_dup_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dup) |->
            (r_feat[0] == DUP_FEATURE && r_feat[1] == DUP_FEATURE
             && r_feat[2] == DUP_FEATURE))
        else $error("duplicate beat without duplicate features");

    a_feat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_dup) |->
            (r_feat[0] <= FEAT_ONE && r_feat[0] >= -FEAT_ONE
             && r_feat[1] <= FEAT_ONE && r_feat[1] >= -FEAT_ONE
             && r_feat[2] <= FEAT_ONE && r_feat[2] >= -FEAT_ONE))
        else $error("feature out of range");

endmodule

`default_nettype wire
